// ----- design/vpa_pkg.sv -----
// ----------------------------------------------------------------------------
// vpa_pkg
// Shared types and constants of the variable partition allocator.
// ----------------------------------------------------------------------------
package vpa_pkg;

    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int ADDR_BITS_DEF    = 16;
    localparam int TAG_BITS_DEF     = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FIT_STRATEGY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE    = 2'd1;

    localparam logic [15:0] POOL_SIZE_RST = 16'd2048;

    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2,
        FIT_NEXT  = 2'd3
    } fit_t;

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FIT    = 2'd1,
        ST_TBL_FULL  = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_NORM,
        S_SCAN,
        S_DEC,
        S_SHIFT,
        S_WR_SPLIT,
        S_WR_ALLOC,
        S_FIND,
        S_MERGE,
        S_MERGE_END,
        S_STATS,
        S_DONE
    } state_t;

endpackage

// ----- design/vpa_req_if.sv -----
// ----------------------------------------------------------------------------
// vpa_req_if
// Request channel: operation, size and owner tag.
// ----------------------------------------------------------------------------
interface vpa_req_if #(
    parameter int ADDR_BITS = vpa_pkg::ADDR_BITS_DEF,
    parameter int TAG_BITS  = vpa_pkg::TAG_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic                 op;
    logic [ADDR_BITS-1:0] alloc_size;
    logic [TAG_BITS-1:0]  owner_tag;

    modport source (output valid, op, alloc_size, owner_tag, input ready);
    modport sink   (input valid, op, alloc_size, owner_tag, output ready);
endinterface

// ----- design/vpa_rsp_if.sv -----
// ----------------------------------------------------------------------------
// vpa_rsp_if
// Result channel: status, segment location and free-space figures.
// ----------------------------------------------------------------------------
interface vpa_rsp_if #(
    parameter int ADDR_BITS = vpa_pkg::ADDR_BITS_DEF,
    parameter int IDX_W     = $clog2(vpa_pkg::MAX_SEGMENTS_DEF)
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           status;
    logic [ADDR_BITS-1:0] seg_start;
    logic [IDX_W-1:0]     seg_index;
    logic [ADDR_BITS-1:0] free_total;
    logic [ADDR_BITS-1:0] largest_free;

    modport source (output valid, status, seg_start, seg_index, free_total, largest_free,
                    input ready);
    modport sink   (input valid, status, seg_start, seg_index, free_total, largest_free,
                    output ready);
endinterface

// ----- design/vpa_seg_ram.sv -----
// ----------------------------------------------------------------------------
// vpa_seg_ram
// Segment table storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module vpa_seg_ram #(
    parameter int DEPTH = vpa_pkg::MAX_SEGMENTS_DEF,
    parameter int WIDTH = 41,
    parameter int AW    = $clog2(vpa_pkg::MAX_SEGMENTS_DEF)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end
endmodule

// ----- design/variable_partition_allocator_top.sv -----
// ----------------------------------------------------------------------------
// variable_partition_allocator_top
// Segment allocator with first/best/worst/next fit and merge on release.
// ----------------------------------------------------------------------------
// One request at a time. The table lives in a single-port-write RAM and every
// step is a streamed pass over it, one entry per cycle, driven by a small
// sequencer: an allocate runs a fit scan, a shift for a split and a
// statistics pass, next fit first brings its start pointer below the segment
// count, and a release runs an owner search, a merge pass and a statistics
// pass. After reset or a pool size write, the table is rebuilt as a single
// free segment before a request is taken.
module variable_partition_allocator_top #(
    parameter int MAX_SEGMENTS = vpa_pkg::MAX_SEGMENTS_DEF,
    parameter int ADDR_BITS    = vpa_pkg::ADDR_BITS_DEF,
    parameter int TAG_BITS     = vpa_pkg::TAG_BITS_DEF,
    parameter int IDX_W        = $clog2(MAX_SEGMENTS)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [vpa_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [vpa_pkg::CFG_DATA_W-1:0]  cfg_data,
    vpa_req_if.sink                         req,
    vpa_rsp_if.source                       rsp
);
    localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);
    localparam int ENTRY_W = 2 * ADDR_BITS + 1 + TAG_BITS;

    vpa_pkg::state_t state_reg, state_next;
    vpa_pkg::fit_t   fit_reg, fit_next;
    logic [15:0]     total_reg, total_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] nptr_reg, nptr_next;

    logic                 op_reg, op_next;
    logic [ADDR_BITS-1:0] size_reg, size_next;
    logic [TAG_BITS-1:0]  tag_reg, tag_next;

    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [IDX_W-1:0] rd_addr_reg, rd_addr_next;
    logic             pv_reg, pv_next;
    logic [IDX_W-1:0] pidx_reg, pidx_next;

    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     k_reg, k_next;
    logic [ADDR_BITS-1:0] cstart_reg, cstart_next;
    logic [ADDR_BITS-1:0] csize_reg, csize_next;

    logic                 have_cur_reg, have_cur_next;
    logic [ADDR_BITS-1:0] cur_start_reg, cur_start_next;
    logic [ADDR_BITS-1:0] cur_size_reg, cur_size_next;
    logic                 cur_free_reg, cur_free_next;
    logic [TAG_BITS-1:0]  cur_owner_reg, cur_owner_next;
    logic [IDX_W-1:0]     w_reg, w_next;

    logic [ADDR_BITS-1:0] sum_reg, sum_next;
    logic [ADDR_BITS-1:0] max_reg, max_next;
    vpa_pkg::status_t     status_reg, status_next;

    logic                 o_valid_reg, o_valid_next;
    logic [1:0]           o_status_reg, o_status_next;
    logic [ADDR_BITS-1:0] o_start_reg, o_start_next;
    logic [IDX_W-1:0]     o_index_reg, o_index_next;
    logic [ADDR_BITS-1:0] o_free_reg, o_free_next;
    logic [ADDR_BITS-1:0] o_largest_reg, o_largest_next;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    logic [ADDR_BITS-1:0] e_start, e_size;
    logic                 e_free;
    logic [TAG_BITS-1:0]  e_owner;
    logic                 accept, cfg_total, stream_done, split, ok_fit, e_free_eff;
    logic [CNT_W-1:0]     rd_inc;

    assign e_owner = ram_rdata[TAG_BITS-1:0];
    assign e_free  = ram_rdata[TAG_BITS];
    assign e_size  = ram_rdata[TAG_BITS+ADDR_BITS:TAG_BITS+1];
    assign e_start = ram_rdata[ENTRY_W-1:TAG_BITS+ADDR_BITS+1];

    assign req.ready   = (state_reg == vpa_pkg::S_IDLE) && !o_valid_reg;
    assign accept      = req.valid && req.ready;
    assign cfg_total   = cfg_we && (cfg_idx == vpa_pkg::CFG_POOL_SIZE);
    assign stream_done = (rem_reg == '0) && !pv_reg;
    assign split       = csize_reg > size_reg;
    assign ok_fit      = found_reg && (size_reg != '0);
    assign rd_inc      = {1'b0, rd_addr_reg} + CNT_W'(1);
    assign e_free_eff  = e_free || (found_reg && (pidx_reg == k_reg));

    assign rsp.valid        = o_valid_reg;
    assign rsp.status       = o_status_reg;
    assign rsp.seg_start    = o_start_reg;
    assign rsp.seg_index    = o_index_reg;
    assign rsp.free_total   = o_free_reg;
    assign rsp.largest_free = o_largest_reg;

    vpa_seg_ram #(
        .DEPTH (MAX_SEGMENTS),
        .WIDTH (ENTRY_W),
        .AW    (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vpa_pkg::S_INIT:
                state_next = vpa_pkg::S_IDLE;
            vpa_pkg::S_IDLE:
            begin
                if (cfg_total)
                    state_next = vpa_pkg::S_INIT;
                else if (accept)
                begin
                    if (req.op == vpa_pkg::OP_RELEASE)
                        state_next = vpa_pkg::S_FIND;
                    else if (fit_reg == vpa_pkg::FIT_NEXT)
                        state_next = vpa_pkg::S_NORM;
                    else
                        state_next = vpa_pkg::S_SCAN;
                end
            end
            vpa_pkg::S_NORM:
                if ({1'b0, rd_addr_reg} < cnt_reg)
                    state_next = vpa_pkg::S_SCAN;
            vpa_pkg::S_SCAN:
                if (stream_done)
                    state_next = vpa_pkg::S_DEC;
            vpa_pkg::S_DEC:
            begin
                if (!ok_fit || (split && cnt_reg == CNT_W'(MAX_SEGMENTS)))
                    state_next = vpa_pkg::S_STATS;
                else if (split)
                    state_next = vpa_pkg::S_SHIFT;
                else
                    state_next = vpa_pkg::S_WR_ALLOC;
            end
            vpa_pkg::S_SHIFT:
                if (stream_done)
                    state_next = vpa_pkg::S_WR_SPLIT;
            vpa_pkg::S_WR_SPLIT:
                state_next = vpa_pkg::S_WR_ALLOC;
            vpa_pkg::S_WR_ALLOC:
                state_next = vpa_pkg::S_STATS;
            vpa_pkg::S_FIND:
                if (stream_done)
                    state_next = vpa_pkg::S_MERGE;
            vpa_pkg::S_MERGE:
                if (stream_done)
                    state_next = vpa_pkg::S_MERGE_END;
            vpa_pkg::S_MERGE_END:
                state_next = vpa_pkg::S_STATS;
            vpa_pkg::S_STATS:
                if (stream_done)
                    state_next = vpa_pkg::S_DONE;
            vpa_pkg::S_DONE:
                state_next = vpa_pkg::S_IDLE;
            default:
                state_next = vpa_pkg::S_INIT;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        fit_next       = fit_reg;
        total_next     = total_reg;
        cnt_next       = cnt_reg;
        nptr_next      = nptr_reg;
        op_next        = op_reg;
        size_next      = size_reg;
        tag_next       = tag_reg;
        rem_next       = rem_reg;
        rd_addr_next   = rd_addr_reg;
        pv_next        = 1'b0;
        pidx_next      = pidx_reg;
        found_next     = found_reg;
        k_next         = k_reg;
        cstart_next    = cstart_reg;
        csize_next     = csize_reg;
        have_cur_next  = have_cur_reg;
        cur_start_next = cur_start_reg;
        cur_size_next  = cur_size_reg;
        cur_free_next  = cur_free_reg;
        cur_owner_next = cur_owner_reg;
        w_next         = w_reg;
        sum_next       = sum_reg;
        max_next       = max_reg;
        status_next    = status_reg;
        o_valid_next   = o_valid_reg;
        o_status_next  = o_status_reg;
        o_start_next   = o_start_reg;
        o_index_next   = o_index_reg;
        o_free_next    = o_free_reg;
        o_largest_next = o_largest_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;

        if (rsp.valid && rsp.ready)
            o_valid_next = 1'b0;

        if (cfg_we && cfg_idx == vpa_pkg::CFG_FIT_STRATEGY)
            fit_next = vpa_pkg::fit_t'(cfg_data[1:0]);
        if (cfg_total)
            total_next = cfg_data;

        // Streamed reads, one entry per cycle
        if ((state_reg == vpa_pkg::S_SCAN || state_reg == vpa_pkg::S_SHIFT ||
             state_reg == vpa_pkg::S_FIND || state_reg == vpa_pkg::S_MERGE ||
             state_reg == vpa_pkg::S_STATS) && rem_reg != '0)
        begin
            rem_next  = rem_reg - CNT_W'(1);
            pv_next   = 1'b1;
            pidx_next = rd_addr_reg;
            if (state_reg == vpa_pkg::S_SHIFT)
                rd_addr_next = rd_addr_reg - IDX_W'(1);
            else if (rd_inc == cnt_reg)
                rd_addr_next = '0;
            else
                rd_addr_next = rd_inc[IDX_W-1:0];
        end

        case (state_reg)
            vpa_pkg::S_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = {ADDR_BITS'(0), ADDR_BITS'(total_reg), 1'b1, TAG_BITS'(0)};
                cnt_next  = CNT_W'(1);
                nptr_next = '0;
            end
            vpa_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next      = req.op;
                    size_next    = req.alloc_size;
                    tag_next     = req.owner_tag;
                    rem_next     = cnt_reg;
                    found_next   = 1'b0;
                    status_next  = vpa_pkg::ST_OK;
                    rd_addr_next = (req.op == vpa_pkg::OP_ALLOC &&
                                    fit_reg == vpa_pkg::FIT_NEXT) ? nptr_reg : '0;
                end
            end
            vpa_pkg::S_NORM:
            begin
                // bring the next-fit pointer below the segment count
                if ({1'b0, rd_addr_reg} >= cnt_reg)
                    rd_addr_next = IDX_W'({1'b0, rd_addr_reg} - cnt_reg);
            end
            vpa_pkg::S_SCAN:
            begin
                if (pv_reg && e_free && e_size >= size_reg &&
                    (!found_reg ||
                     (fit_reg == vpa_pkg::FIT_BEST && e_size < csize_reg) ||
                     (fit_reg == vpa_pkg::FIT_WORST && e_size > csize_reg)))
                begin
                    found_next  = 1'b1;
                    k_next      = pidx_reg;
                    cstart_next = e_start;
                    csize_next  = e_size;
                end
            end
            vpa_pkg::S_DEC:
            begin
                if (!ok_fit)
                    status_next = vpa_pkg::ST_NO_FIT;
                else if (split && cnt_reg == CNT_W'(MAX_SEGMENTS))
                    status_next = vpa_pkg::ST_TBL_FULL;
                else
                begin
                    if (fit_reg == vpa_pkg::FIT_NEXT)
                        nptr_next = ({1'b0, k_reg} + CNT_W'(1) == cnt_reg) ?
                                    '0 : k_reg + IDX_W'(1);
                    rem_next     = cnt_reg - CNT_W'(1) - CNT_W'(k_reg);
                    rd_addr_next = IDX_W'(cnt_reg - CNT_W'(1));
                end
            end
            vpa_pkg::S_SHIFT:
            begin
                if (pv_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pidx_reg + IDX_W'(1);
                    ram_wdata = ram_rdata;
                end
            end
            vpa_pkg::S_WR_SPLIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = k_reg + IDX_W'(1);
                ram_wdata = {cstart_reg + size_reg, csize_reg - size_reg, 1'b1,
                             TAG_BITS'(0)};
            end
            vpa_pkg::S_WR_ALLOC:
            begin
                ram_we    = 1'b1;
                ram_waddr = k_reg;
                ram_wdata = {cstart_reg, split ? size_reg : csize_reg, 1'b0, tag_reg};
                if (split)
                    cnt_next = cnt_reg + CNT_W'(1);
            end
            vpa_pkg::S_FIND:
            begin
                if (pv_reg && !found_reg && !e_free && e_owner == tag_reg)
                begin
                    found_next = 1'b1;
                    k_next     = pidx_reg;
                end
                if (stream_done)
                begin
                    status_next   = found_reg ? vpa_pkg::ST_OK : vpa_pkg::ST_NOT_FOUND;
                    rem_next      = cnt_reg;
                    rd_addr_next  = '0;
                    have_cur_next = 1'b0;
                    w_next        = '0;
                end
            end
            vpa_pkg::S_MERGE:
            begin
                // compaction pass: runs of free entries fold into one
                if (pv_reg)
                begin
                    if (have_cur_reg && cur_free_reg && e_free_eff)
                        cur_size_next = cur_size_reg + e_size;
                    else
                    begin
                        if (have_cur_reg)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = w_reg;
                            ram_wdata = {cur_start_reg, cur_size_reg, cur_free_reg,
                                         cur_owner_reg};
                            w_next    = w_reg + IDX_W'(1);
                        end
                        cur_start_next = e_start;
                        cur_size_next  = e_size;
                        cur_free_next  = e_free_eff;
                        cur_owner_next = e_owner;
                        have_cur_next  = 1'b1;
                    end
                end
            end
            vpa_pkg::S_MERGE_END:
            begin
                ram_we    = 1'b1;
                ram_waddr = w_reg;
                ram_wdata = {cur_start_reg, cur_size_reg, cur_free_reg, cur_owner_reg};
                cnt_next  = CNT_W'(w_reg) + CNT_W'(1);
            end
            vpa_pkg::S_STATS:
            begin
                if (pv_reg && e_free)
                begin
                    sum_next = sum_reg + e_size;
                    if (e_size > max_reg)
                        max_next = e_size;
                end
            end
            vpa_pkg::S_DONE:
            begin
                o_valid_next   = 1'b1;
                o_status_next  = status_reg;
                o_start_next   = (status_reg == vpa_pkg::ST_OK && op_reg == vpa_pkg::OP_ALLOC)
                                 ? cstart_reg : '0;
                o_index_next   = (status_reg == vpa_pkg::ST_OK) ? k_reg : '0;
                o_free_next    = sum_reg;
                o_largest_next = max_reg;
            end
            default:
            begin
            end
        endcase

        if (state_next == vpa_pkg::S_STATS && state_reg != vpa_pkg::S_STATS)
        begin
            rem_next     = cnt_next;
            rd_addr_next = '0;
            sum_next     = '0;
            max_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= vpa_pkg::S_INIT;
            fit_reg     <= vpa_pkg::FIT_BEST;
            total_reg   <= vpa_pkg::POOL_SIZE_RST;
            cnt_reg     <= CNT_W'(1);
            nptr_reg    <= '0;
            rem_reg     <= '0;
            rd_addr_reg <= '0;
            pv_reg      <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fit_reg     <= fit_next;
            total_reg   <= total_next;
            cnt_reg     <= cnt_next;
            nptr_reg    <= nptr_next;
            rem_reg     <= rem_next;
            rd_addr_reg <= rd_addr_next;
            pv_reg      <= pv_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        size_reg      <= size_next;
        tag_reg       <= tag_next;
        pidx_reg      <= pidx_next;
        found_reg     <= found_next;
        k_reg         <= k_next;
        cstart_reg    <= cstart_next;
        csize_reg     <= csize_next;
        have_cur_reg  <= have_cur_next;
        cur_start_reg <= cur_start_next;
        cur_size_reg  <= cur_size_next;
        cur_free_reg  <= cur_free_next;
        cur_owner_reg <= cur_owner_next;
        w_reg         <= w_next;
        sum_reg       <= sum_next;
        max_reg       <= max_next;
        status_reg    <= status_next;
        o_status_reg  <= o_status_next;
        o_start_reg   <= o_start_next;
        o_index_reg   <= o_index_next;
        o_free_reg    <= o_free_next;
        o_largest_reg <= o_largest_next;
    end
endmodule

// ----- tb/variable_partition_allocator_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_partition_allocator_top_tb
// Self-checking bench for the segment allocator. A scoreboard class keeps its
// own copy of the segment table, predicts each result from the accepted
// requests and compares every result beat field by field. The stimulus is a
// short directed part, then random phases that cover every fit strategy and
// several memory sizes, with random idling on both channels.
// ----------------------------------------------------------------------------
module variable_partition_allocator_top_tb;

    localparam int SEGS     = vpa_pkg::MAX_SEGMENTS_DEF;
    localparam int WD_LIMIT = 5000;

    typedef struct packed {
        vpa_pkg::status_t status;
        logic [15:0]      seg_start;
        logic [5:0]       seg_index;
        logic [15:0]      free_total;
        logic [15:0]      largest_free;
    } alloc_result_t;

    class alloc_scoreboard;
        vpa_pkg::fit_t fit;
        logic [15:0]   mem_size;
        logic [15:0]   tbl_start [SEGS];
        logic [15:0]   tbl_size  [SEGS];
        logic          tbl_free  [SEGS];
        logic [7:0]    tbl_owner [SEGS];
        int            nseg;
        int            nptr;
        alloc_result_t pending_q [$];
        int            errors;

        function void rebuild();
            for (int i = 0; i < SEGS; i++)
            begin
                tbl_start[i] = '0;
                tbl_size[i]  = '0;
                tbl_free[i]  = 1'b0;
                tbl_owner[i] = '0;
            end
            tbl_size[0] = mem_size;
            tbl_free[0] = 1'b1;
            nseg = 1;
            nptr = 0;
        endfunction

        function new();
            fit      = vpa_pkg::FIT_BEST;
            mem_size = vpa_pkg::POOL_SIZE_RST;
            errors   = 0;
            rebuild();
        endfunction

        function void write_reg(logic [vpa_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
            if (idx == vpa_pkg::CFG_FIT_STRATEGY)
                fit = vpa_pkg::fit_t'(data[1:0]);
            else if (idx == vpa_pkg::CFG_POOL_SIZE)
            begin
                mem_size = data;
                rebuild();
            end
        endfunction

        function bit bool_fits(int i, logic [15:0] sz);
            return tbl_free[i] && tbl_size[i] >= sz;
        endfunction

        function int choose_segment(logic [15:0] sz);
            int pick;
            int k;
            pick = SEGS;
            if (fit != vpa_pkg::FIT_NEXT)
            begin
                for (int i = 0; i < nseg; i++)
                begin
                    if (bool_fits(i, sz))
                    begin
                        if (pick == SEGS ||
                            (fit == vpa_pkg::FIT_BEST && tbl_size[i] < tbl_size[pick]) ||
                            (fit == vpa_pkg::FIT_WORST && tbl_size[i] > tbl_size[pick]))
                            pick = i;
                        if (fit == vpa_pkg::FIT_FIRST)
                            break;
                    end
                end
            end
            else
            begin
                for (int i = 0; i < nseg; i++)
                begin
                    k = ((nptr % nseg) + i) % nseg;
                    if (bool_fits(k, sz))
                    begin
                        pick = k;
                        break;
                    end
                end
            end
            return pick;
        endfunction

        function void coalesce();
            int i;
            i = 0;
            while (i + 1 < nseg)
            begin
                if (tbl_free[i] && tbl_free[i+1])
                begin
                    tbl_size[i] = tbl_size[i] + tbl_size[i+1];
                    for (int j = i + 1; j + 1 < nseg; j++)
                    begin
                        tbl_start[j] = tbl_start[j+1];
                        tbl_size[j]  = tbl_size[j+1];
                        tbl_free[j]  = tbl_free[j+1];
                        tbl_owner[j] = tbl_owner[j+1];
                    end
                    nseg--;
                end
                else
                    i++;
            end
        endfunction

        function void note_request(vpa_pkg::op_t op, logic [15:0] sz, logic [7:0] tag);
            alloc_result_t r;
            int k;
            r = '0;
            r.status = vpa_pkg::ST_OK;
            if (op == vpa_pkg::OP_ALLOC)
            begin
                k = (sz == 0) ? SEGS : choose_segment(sz);
                if (k >= SEGS)
                    r.status = vpa_pkg::ST_NO_FIT;
                else if (tbl_size[k] > sz && nseg >= SEGS)
                    r.status = vpa_pkg::ST_TBL_FULL;
                else
                begin
                    if (fit == vpa_pkg::FIT_NEXT)
                        nptr = (k + 1) % nseg;
                    if (tbl_size[k] > sz)
                    begin
                        for (int i = nseg; i > k + 1; i--)
                        begin
                            tbl_start[i] = tbl_start[i-1];
                            tbl_size[i]  = tbl_size[i-1];
                            tbl_free[i]  = tbl_free[i-1];
                            tbl_owner[i] = tbl_owner[i-1];
                        end
                        tbl_start[k+1] = tbl_start[k] + sz;
                        tbl_size[k+1]  = tbl_size[k] - sz;
                        tbl_free[k+1]  = 1'b1;
                        tbl_owner[k+1] = '0;
                        tbl_size[k]    = sz;
                        nseg++;
                    end
                    tbl_free[k]  = 1'b0;
                    tbl_owner[k] = tag;
                    r.seg_start  = tbl_start[k];
                    r.seg_index  = k[5:0];
                end
            end
            else
            begin
                r.status = vpa_pkg::ST_NOT_FOUND;
                for (int i = 0; i < nseg; i++)
                begin
                    if (!tbl_free[i] && tbl_owner[i] == tag)
                    begin
                        tbl_free[i] = 1'b1;
                        r.status    = vpa_pkg::ST_OK;
                        r.seg_index = i[5:0];
                        break;
                    end
                end
                coalesce();
            end
            for (int i = 0; i < nseg; i++)
            begin
                if (tbl_free[i])
                begin
                    r.free_total = r.free_total + tbl_size[i];
                    if (tbl_size[i] > r.largest_free)
                        r.largest_free = tbl_size[i];
                end
            end
            pending_q.push_back(r);
        endfunction

        function void check_result(alloc_result_t got);
            alloc_result_t exp;
            if (pending_q.size() == 0)
            begin
                $error("unexpected result beat");
                errors++;
                return;
            end
            exp = pending_q.pop_front();
            if (got.status !== exp.status)
            begin
                $error("status exp %0d got %0d", exp.status, got.status);
                errors++;
            end
            if (got.seg_start !== exp.seg_start)
            begin
                $error("seg_start exp %0d got %0d", exp.seg_start, got.seg_start);
                errors++;
            end
            if (got.seg_index !== exp.seg_index)
            begin
                $error("seg_index exp %0d got %0d", exp.seg_index, got.seg_index);
                errors++;
            end
            if (got.free_total !== exp.free_total)
            begin
                $error("free_total exp %0d got %0d", exp.free_total, got.free_total);
                errors++;
            end
            if (got.largest_free !== exp.largest_free)
            begin
                $error("largest_free exp %0d got %0d", exp.largest_free, got.largest_free);
                errors++;
            end
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [vpa_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [vpa_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           idling_on;
    int                             rsp_stall = 0;
    int                             quiet_cycles = 0;

    vpa_req_if req_if ();
    vpa_rsp_if rsp_if ();

    alloc_scoreboard sb;

    variable_partition_allocator_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .req      (req_if.sink),
        .rsp      (rsp_if.source)
    );

    always #5 clk = ~clk;

    task automatic send_request(vpa_pkg::op_t op, logic [15:0] sz, logic [7:0] tag);
        int gap;
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 19);
            @(negedge clk);
            req_if.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_if.valid      = 1'b1;
        req_if.op         = op;
        req_if.alloc_size = sz;
        req_if.owner_tag  = tag;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        sb.note_request(op, sz, tag);
    endtask

    task automatic write_reg(logic [vpa_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
        @(negedge clk);
        req_if.valid = 1'b0;
        while (sb.pending_q.size() != 0)
            @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(posedge clk);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Random result-side backpressure in bursts.
    always @(negedge clk)
    begin
        if (rsp_stall > 0)
        begin
            rsp_stall    <= rsp_stall - 1;
            rsp_if.ready <= 1'b0;
        end
        else if (idling_on && $urandom_range(0, 7) == 0)
        begin
            rsp_stall    <= $urandom_range(0, 18);
            rsp_if.ready <= 1'b0;
        end
        else
            rsp_if.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_result({vpa_pkg::status_t'(rsp_if.status), rsp_if.seg_start,
                             rsp_if.seg_index, rsp_if.free_total, rsp_if.largest_free});
    end

    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT)
        begin
            $display("[variable_partition_allocator_top] ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] mem_sizes [8];
        int          span;
        logic [15:0] sz;
        logic [7:0]  tag;
        mem_sizes = '{16'd65535, 16'd1, 16'd300, 16'd2048, 16'd100, 16'd4096, 16'd70,
                      16'd1000};
        sb                = new();
        clk               = 1'b0;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = '0;
        cfg_data          = '0;
        req_if.valid      = 1'b0;
        req_if.op         = vpa_pkg::OP_ALLOC;
        req_if.alloc_size = '0;
        req_if.owner_tag  = '0;
        idling_on         = 1'b1;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset config, best fit over 2048 units
        send_request(vpa_pkg::OP_ALLOC, 16'd0, 8'd1);
        send_request(vpa_pkg::OP_ALLOC, 16'hFFFF, 8'd1);
        send_request(vpa_pkg::OP_RELEASE, 16'd0, 8'd9);
        send_request(vpa_pkg::OP_ALLOC, 16'd2048, 8'hFF);
        send_request(vpa_pkg::OP_ALLOC, 16'd1, 8'd2);
        send_request(vpa_pkg::OP_RELEASE, 16'd0, 8'hFF);
        send_request(vpa_pkg::OP_ALLOC, 16'd100, 8'd3);
        send_request(vpa_pkg::OP_ALLOC, 16'd50, 8'd4);
        send_request(vpa_pkg::OP_ALLOC, 16'd200, 8'd5);
        send_request(vpa_pkg::OP_RELEASE, 16'd0, 8'd3);
        send_request(vpa_pkg::OP_RELEASE, 16'd0, 8'd5);
        send_request(vpa_pkg::OP_ALLOC, 16'd40, 8'hAA);
        send_request(vpa_pkg::OP_RELEASE, 16'd0, 8'd4);
        write_reg(vpa_pkg::CFG_POOL_SIZE, 16'hFFFF);
        write_reg(vpa_pkg::CFG_FIT_STRATEGY, vpa_pkg::FIT_FIRST);
        send_request(vpa_pkg::OP_ALLOC, 16'hFFFF, 8'h55);
        send_request(vpa_pkg::OP_ALLOC, 16'd1, 8'h55);
        send_request(vpa_pkg::OP_RELEASE, 16'd0, 8'h55);
        write_reg(vpa_pkg::CFG_POOL_SIZE, 16'd0);
        send_request(vpa_pkg::OP_ALLOC, 16'd1, 8'd7);
        send_request(vpa_pkg::OP_RELEASE, 16'd0, 8'd7);
        // index past the register list has no effect
        write_reg(2'd3, 16'hFFFF);
        write_reg(vpa_pkg::CFG_POOL_SIZE, 16'd80);
        for (int i = 0; i < 70; i++)
            send_request(vpa_pkg::OP_ALLOC, 16'd1, i[7:0]);
        send_request(vpa_pkg::OP_ALLOC, 16'd17, 8'd200);

        // random phases over every strategy and several memory sizes
        for (int p = 0; p < 8; p++)
        begin
            write_reg(vpa_pkg::CFG_FIT_STRATEGY, vpa_pkg::fit_t'(p % 4));
            write_reg(vpa_pkg::CFG_POOL_SIZE, mem_sizes[p]);
            if (p == 7)
                idling_on = 1'b0;
            span = (mem_sizes[p] / 12) + 1;
            for (int n = 0; n < 225; n++)
            begin
                tag = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
                case ($urandom_range(0, 9))
                    0:       sz = 16'($urandom);
                    1:       sz = 16'($urandom_range(1, 8));
                    default: sz = 16'($urandom_range(1, span));
                endcase
                if ($urandom_range(0, 9) < 4)
                    send_request(vpa_pkg::OP_RELEASE, 16'($urandom), tag);
                else
                    send_request(vpa_pkg::OP_ALLOC, sz, tag);
            end
        end

        @(negedge clk);
        req_if.valid = 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (sb.errors == 0)
            $display("[variable_partition_allocator_top] OK");
        else
            $display("[variable_partition_allocator_top] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
design/vpa_pkg.sv
design/vpa_req_if.sv
design/vpa_rsp_if.sv
design/vpa_seg_ram.sv
design/variable_partition_allocator_top.sv
tb/variable_partition_allocator_top_tb.sv
